@@ hw/rtl/mhpq_pkg.sv @@
// Shared types and codes for the max-heap priority queue.
// No dependencies; imported by mhpq_ctrl and max_heap_priority_queue.
`default_nettype none

package mhpq_pkg;

	// command codes
	localparam logic KIND_PUSH = 1'b0;
	localparam logic KIND_POP  = 1'b1;

	// result status codes
	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_FULL  = 2'd1;
	localparam logic [1:0] STATUS_EMPTY = 2'd2;

	typedef struct packed {
		logic        kind;
		logic [31:0] key;
	} in_word_t;

	typedef struct packed {
		logic [31:0] popped_key;
		logic [1:0]  status;
		logic [10:0] count_after;
	} out_word_t;

	typedef struct packed {
		logic      done;
		out_word_t word;
	} ctrl_res_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_POP_FETCH,
		S_DN_READ,
		S_DN_EVAL,
		S_UP_READ,
		S_UP_EVAL
	} state_t;

endpackage

`default_nettype wire

@@ hw/rtl/max_heap_priority_queue.sv @@
// Binary max-heap priority queue over mhpq_ctrl and mhpq_ram; one command at a time.
// Push writes the key at the next free slot and sifts it up; pop fetches the root and last word,
// then sifts that word down from the root (or ends there if the pop empties the heap).
// Each level moved takes a read state and an evaluate state. Refused words never raise busy.
// busy drops as done rises, so the next word is taken from then on; done cannot be stalled.
// Reset (arst_n low) empties the heap and selects unsigned compare; RAM is not cleared.
`default_nettype none

module max_heap_priority_queue
	import mhpq_pkg::*;
#(
	parameter int CAPACITY  = 1024,
	parameter int KEY_WIDTH = 32
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	input  wire in_word_t  cmd,
	output      logic      busy,
	output      logic      done,
	output      out_word_t result,
	input  wire logic      cfg_wr_en,
	input  wire logic      cfg_wr_data
);

	localparam int AW = $clog2(CAPACITY);

	logic                 key_signed_q;
	logic                 done_q;
	out_word_t            result_q;
	ctrl_res_t            res;
	logic                 ram_we;
	logic [AW-1:0]        ram_waddr, ram_raddr_a, ram_raddr_b;
	logic [KEY_WIDTH-1:0] ram_wdata, ram_rdata_a, ram_rdata_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_signed_q <= 1'b0;
			done_q       <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				key_signed_q <= cfg_wr_data;
			end
			done_q <= res.done;
		end
	end

	// result word registered when the sequencer finishes, held until the next result
	always_ff @(posedge clk) begin
		if (res.done) begin
			result_q <= res.word;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	mhpq_ctrl #(
		.CAPACITY  (CAPACITY),
		.KEY_WIDTH (KEY_WIDTH)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.cmd         (cmd),
		.key_signed  (key_signed_q),
		.busy        (busy),
		.res         (res),
		.ram_we      (ram_we),
		.ram_waddr   (ram_waddr),
		.ram_wdata   (ram_wdata),
		.ram_raddr_a (ram_raddr_a),
		.ram_raddr_b (ram_raddr_b),
		.ram_rdata_a (ram_rdata_a),
		.ram_rdata_b (ram_rdata_b)
	);

	mhpq_ram #(
		.WIDTH (KEY_WIDTH),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.raddr_a (ram_raddr_a),
		.raddr_b (ram_raddr_b),
		.rdata_a (ram_rdata_a),
		.rdata_b (ram_rdata_b)
	);

endmodule

`default_nettype wire

@@ hw/rtl/mhpq_ram.sv @@
// Generic synchronous RAM: one write port, two read ports, registered read.
// No dependencies.
`default_nettype none

module mhpq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output      logic [WIDTH-1:0]         rdata_a,
	output      logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

`default_nettype wire

@@ hw/rtl/mhpq_ctrl.sv @@
// Heap sequencer: push/pop control, sift-up and sift-down over the key RAM.
// Depends on mhpq_pkg; drives the ports of one mhpq_ram instance.
`default_nettype none

module mhpq_ctrl
	import mhpq_pkg::*;
#(
	parameter int CAPACITY  = 1024,
	parameter int KEY_WIDTH = 32
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire in_word_t                    cmd,
	input  wire logic                        key_signed,
	output      logic                        busy,
	output      ctrl_res_t                   res,
	output      logic                        ram_we,
	output      logic [$clog2(CAPACITY)-1:0] ram_waddr,
	output      logic [KEY_WIDTH-1:0]        ram_wdata,
	output      logic [$clog2(CAPACITY)-1:0] ram_raddr_a,
	output      logic [$clog2(CAPACITY)-1:0] ram_raddr_b,
	input  wire logic [KEY_WIDTH-1:0]        ram_rdata_a,
	input  wire logic [KEY_WIDTH-1:0]        ram_rdata_b
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = AW + 2;

	state_t               state_q, state_d;
	logic [CW-1:0]        count_q, count_d;
	logic [AW-1:0]        pos_q, pos_d;
	logic [KEY_WIDTH-1:0] key_q, key_d;
	logic [KEY_WIDTH-1:0] popped_q, popped_d;

	logic [KEY_WIDTH+31:0] key_ext;
	logic [KEY_WIDTH-1:0]  key_in;
	logic [KEY_WIDTH+31:0] popped_ext;
	logic [CW+10:0]        count_ext;
	logic [XW-1:0]         cnt_x, lc_x, rc_x, pick_x;
	logic [AW-1:0]         pos_m1, up_pos;
	logic                  take_r, full;
	logic [KEY_WIDTH-1:0]  pick_d;
	logic [1:0]            status;
	logic                  done_d;

	// a ranks at or below b; signed compare by flipping the sign bit
	function automatic logic key_le(input logic [KEY_WIDTH-1:0] a,
			input logic [KEY_WIDTH-1:0] b, input logic sgn);
		logic [KEY_WIDTH-1:0] m;
		m = '0;
		m[KEY_WIDTH-1] = sgn;
		return (a ^ m) <= (b ^ m);
	endfunction

	assign key_ext = {{KEY_WIDTH{1'b0}}, cmd.key};
	assign key_in  = key_ext[KEY_WIDTH-1:0];
	assign full    = (count_q == CW'(CAPACITY));

	assign cnt_x  = {{(XW-CW){1'b0}}, count_q};
	assign lc_x   = {1'b0, pos_q, 1'b1};
	assign rc_x   = {1'b0, pos_q, 1'b0} + XW'(2);
	assign pos_m1 = pos_q - AW'(1);
	assign up_pos = pos_m1 >> 1;

	// right child wins ties; left only if strictly larger
	assign take_r = (rc_x < cnt_x) && key_le(ram_rdata_a, ram_rdata_b, key_signed);
	assign pick_x = take_r ? rc_x : lc_x;
	assign pick_d = take_r ? ram_rdata_b : ram_rdata_a;

	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		pos_q    <= pos_d;
		key_q    <= key_d;
		popped_q <= popped_d;
	end

	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		pos_d       = pos_q;
		key_d       = key_q;
		popped_d    = popped_q;
		ram_we      = 1'b0;
		ram_waddr   = pos_q;
		ram_wdata   = key_q;
		ram_raddr_a = '0;
		ram_raddr_b = '0;
		done_d      = 1'b0;
		status      = STATUS_OK;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					if (cmd.kind == KIND_PUSH) begin
						if (full) begin
							done_d = 1'b1;
							status = STATUS_FULL;
						end else begin
							count_d  = count_q + CW'(1);
							pos_d    = count_q[AW-1:0];
							key_d    = key_in;
							popped_d = '0;
							state_d  = S_UP_READ;
						end
					end else begin
						if (count_q == '0) begin
							done_d = 1'b1;
							status = STATUS_EMPTY;
						end else begin
							// fetch root and last word together
							ram_raddr_b = count_q[AW-1:0] - AW'(1);
							count_d     = count_q - CW'(1);
							state_d     = S_POP_FETCH;
						end
					end
				end
			end
			S_POP_FETCH: begin
				popped_d = ram_rdata_a;
				key_d    = ram_rdata_b;
				pos_d    = '0;
				if (count_q == '0) begin
					done_d  = 1'b1;
					state_d = S_IDLE;
				end else begin
					state_d = S_DN_READ;
				end
			end
			S_DN_READ: begin
				if (lc_x >= cnt_x) begin
					ram_we  = 1'b1;
					done_d  = 1'b1;
					state_d = S_IDLE;
				end else begin
					ram_raddr_a = lc_x[AW-1:0];
					ram_raddr_b = rc_x[AW-1:0];
					state_d     = S_DN_EVAL;
				end
			end
			S_DN_EVAL: begin
				ram_we = 1'b1;
				if (key_le(key_q, pick_d, key_signed)) begin
					ram_wdata = pick_d;
					pos_d     = pick_x[AW-1:0];
					state_d   = S_DN_READ;
				end else begin
					done_d  = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_UP_READ: begin
				if (pos_q == '0) begin
					ram_we  = 1'b1;
					done_d  = 1'b1;
					state_d = S_IDLE;
				end else begin
					ram_raddr_a = up_pos;
					state_d     = S_UP_EVAL;
				end
			end
			S_UP_EVAL: begin
				ram_we = 1'b1;
				if (key_le(ram_rdata_a, key_q, key_signed)) begin
					ram_wdata = ram_rdata_a;
					pos_d     = up_pos;
					state_d   = S_UP_READ;
				end else begin
					done_d  = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign popped_ext = {32'd0, popped_d};
	assign count_ext  = {11'd0, count_d};

	always_comb begin
		res.done             = done_d;
		res.word.popped_key  = (status == STATUS_OK) ? popped_ext[31:0] : 32'd0;
		res.word.status      = status;
		res.word.count_after = count_ext[10:0];
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("heap count beyond capacity");

	a_write_in_heap: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> ({{(XW-AW){1'b0}}, ram_waddr} < cnt_x))
		else $error("write outside occupied slots");

	a_hole_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DN_EVAL) |-> ({2'b00, pos_q} < cnt_x))
		else $error("sift-down hole outside heap");

	a_done_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res.done |=> (state_q == S_IDLE))
		else $error("result word without return to idle");
`endif

endmodule

`default_nettype wire
